/* hw/rtl/clsr_pkg.sv */
// Shared types, codes and the glyph ROM for the character display shadow buffer.
// Used by char_lcd_shadow_refresh; depends on nothing else.
`default_nettype none

package clsr_pkg;

  localparam int COL_W = 5;
  localparam int ROW_W = 2;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_SCAN  = 2'd1;
  localparam logic [1:0] ACT_BUILD = 2'd2;

  localparam logic [2:0] EFF_NONE   = 3'd0;
  localparam logic [2:0] EFF_FLASH  = 3'd1;
  localparam logic [2:0] EFF_ROTATE = 3'd2;
  localparam logic [2:0] EFF_SLIDE  = 3'd3;
  localparam logic [2:0] EFF_INVERT = 3'd4;
  localparam logic [2:0] EFF_MASK   = 3'd5;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_CHAR = 2'd1;
  localparam logic [1:0] MARK_ICON = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CMD_GOTO   = 8'h80;
  localparam logic [7:0] CMD_CGRAM  = 8'h40;
  localparam logic [7:0] ROW_XOR    = 8'hE0;
  localparam int         GLYPHS     = 20;

  typedef struct packed {
    logic [4:0] shift_amount;
    logic [2:0] effect;
    logic [2:0] icon_slot;
    logic [4:0] glyph_select;
    logic       force_req;
    logic [7:0] char_code;
    logic [1:0] row;
    logic [4:0] column;
  } in_fields_t;

  typedef struct packed {
    logic [1:0] mark;
    logic [7:0] code;
  } cell_t;

  function automatic logic [7:0] line_base(input logic [1:0] y);
    logic [7:0] b;
    case (y)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // row i of a glyph sits in bits 8i+7..8i
  function automatic logic [63:0] glyph_rom(input logic [4:0] g);
    logic [63:0] v;
    case (g)
      5'd0:    v = 64'h04040404_0404040E;
      5'd1:    v = 64'h00000000_00001F1F;
      5'd2:    v = 64'h1F1F0000_00000000;
      5'd3:    v = 64'h1F1F0000_00001F1F;
      5'd4:    v = 64'h001B1B1F_1F0E0400;
      5'd5:    v = 64'h001F1B1B_1F11110E;
      5'd6:    v = 64'h000E1111_110A0602;
      5'd7:    v = 64'h000E0A11_1111110E;
      5'd8:    v = 64'h000E0A15_1515110E;
      5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
               v = 64'h00111111_11110818;
      5'd16:   v = 64'h00071319_1C1E1F0E;
      5'd17, 5'd18, 5'd19:
               v = 64'h001F151F_151F151F;
      default: v = 64'h0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] build_glyph(input logic [4:0] g, input logic [2:0] eff,
                                               input logic [4:0] sh);
    logic [63:0] src;
    logic [63:0] msk;
    logic [63:0] res;
    logic [2:0]  idx;
    src = glyph_rom(g);
    msk = glyph_rom(sh);
    res = '0;
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i) - sh[2:0];
      case (eff)
        EFF_ROTATE: res[8*i +: 8] = src[{idx, 3'b000} +: 8];
        EFF_SLIDE: begin
          if (32'(sh) <= i) res[8*i +: 8] = src[{idx, 3'b000} +: 8];
        end
        EFF_INVERT: res[8*i +: 8] = ~src[8*i +: 8];
        EFF_MASK:   res[8*i +: 8] = src[8*i +: 8] ^ msk[8*i +: 8];
        default:    res[8*i +: 8] = 8'h00;
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/char_lcd_shadow_refresh.sv */
// Items are taken in ST_IDLE only: an on-grid write reads its cell and checks it in ST_WCHK, a
// scan tick reads its cell in ST_SCHK and, if marked, emits its bytes in ST_EMIT, one byte a
// cycle unless out_tready stalls (2 or 12 bytes); an icon build gives one status in ST_BLD.
// An off-grid write or an unknown action is dropped. No new item is taken before the current
// one is done; writes and scans read and may then write the cell memory.
// Reset (rst_n low, synchronous): cells read as spaces marked changed, icons zero, scan at 0.
`default_nettype none

module char_lcd_shadow_refresh
  import clsr_pkg::*;
#(
  parameter int ROWS       = 4,
  parameter int COLS       = 20,
  parameter int ICON_SLOTS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // column, row, char_code, force_req, glyph_select,
                                  // icon_slot, effect, shift_amount
  input  wire  [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // lcd_byte, is_data, icon_changed, zero fill
  output logic        out_tuser,  // result_kind
  output logic        out_tlast   // last
);

  localparam int NCELLS = ROWS * COLS;
  localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int SLOT_W = (ICON_SLOTS > 1) ? $clog2(ICON_SLOTS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WCHK = 3'd1;
  localparam logic [2:0] ST_SCHK = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_BLD  = 3'd4;

  localparam logic [3:0] SEQ_CGRAM = 4'd0;
  localparam logic [3:0] SEQ_HOME  = 4'd9;
  localparam logic [3:0] SEQ_GOTO  = 4'd10;
  localparam logic [3:0] SEQ_DATA  = 4'd11;

  logic [2:0]        state_r, state_nxt;
  in_fields_t        fld_r;
  in_fields_t        in_f;
  logic              in_xfer;
  logic [CELL_W-1:0] addr_r, wr_addr;
  logic              on_grid;

  logic [CELL_W-1:0] scan_cell_r;
  logic [COL_W-1:0]  scan_x_r, x_r;
  logic [ROW_W-1:0]  scan_y_r, y_r;

  cell_t             cell_mem [NCELLS];
  cell_t             cmem_rdata_r, cmem_wdata, crd;
  logic              cmem_re, cmem_we;
  logic [CELL_W-1:0] cmem_raddr;
  logic [NCELLS-1:0] cvld_r;

  logic [63:0]       icon_mem [ICON_SLOTS];
  logic [63:0]       imem_rdata_r, imem_wdata, old_glyph, new_glyph;
  logic              imem_re, imem_we;
  logic [SLOT_W-1:0] imem_raddr, slot_idx;
  logic [ICON_SLOTS-1:0] ivld_r;
  logic              iok_r, iok_nxt;
  logic              slot_ok, slot_ok_r;

  logic [7:0]        code_r;
  logic [3:0]        seq_r;
  logic              is_icon, copy_eff, bld_chg;
  logic [2:0]        row_idx;

  logic              out_vld_r, out_kind_r, out_data_r, out_chg_r, out_last_r;
  logic [7:0]        out_byte_r;
  logic              out_free, out_load;
  logic              ld_kind, ld_data, ld_chg, ld_last;
  logic [7:0]        ld_byte;

  assign in_f      = in_fields_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign on_grid   = (32'(in_f.column) < COLS) && (32'(in_f.row) < ROWS);
  assign wr_addr   = CELL_W'(32'(in_f.row) * COLS + 32'(in_f.column));
  assign slot_ok   = 32'(in_f.icon_slot) < ICON_SLOTS;
  assign slot_idx  = fld_r.icon_slot[SLOT_W-1:0];

  assign crd       = cvld_r[addr_r] ? cmem_rdata_r : cell_t'({MARK_CHAR, CHAR_SPACE});
  assign is_icon   = (crd.mark == MARK_ICON) && (crd.code <= 8'd3);
  assign out_free  = !out_vld_r || out_tready;

  assign old_glyph = (slot_ok_r && ivld_r[slot_idx]) ? imem_rdata_r : 64'h0;
  assign copy_eff  = (fld_r.effect == EFF_NONE) ||
                     ((fld_r.effect == EFF_FLASH) && (fld_r.shift_amount != 5'd0));
  assign new_glyph = copy_eff ? glyph_rom(fld_r.glyph_select)
                              : build_glyph(fld_r.glyph_select, fld_r.effect,
                                            fld_r.shift_amount);
  assign bld_chg   = slot_ok_r && (copy_eff || (old_glyph != new_glyph));
  assign row_idx   = 3'(seq_r - 4'd1);

  always_comb begin
    state_nxt  = state_r;
    cmem_re    = 1'b0;
    cmem_raddr = scan_cell_r;
    cmem_we    = 1'b0;
    cmem_wdata = cell_t'({MARK_NONE, crd.code});
    imem_re    = 1'b0;
    imem_raddr = in_f.icon_slot[SLOT_W-1:0];
    imem_we    = 1'b0;
    imem_wdata = new_glyph;
    iok_nxt    = iok_r;
    out_load   = 1'b0;
    ld_kind    = 1'b0;
    ld_byte    = 8'h00;
    ld_data    = 1'b0;
    ld_chg     = 1'b0;
    ld_last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            ACT_WRITE: begin
              if (on_grid) begin
                cmem_re    = 1'b1;
                cmem_raddr = wr_addr;
                state_nxt  = ST_WCHK;
              end
            end
            ACT_SCAN: begin
              cmem_re   = 1'b1;
              state_nxt = ST_SCHK;
            end
            ACT_BUILD: begin
              imem_re   = slot_ok;
              state_nxt = ST_BLD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WCHK: begin
        if (fld_r.force_req || (crd.code != fld_r.char_code)) begin
          cmem_we    = 1'b1;
          cmem_wdata = cell_t'({(fld_r.char_code > 8'd7) ? MARK_CHAR : MARK_ICON,
                                fld_r.char_code});
        end
        state_nxt = ST_IDLE;
      end
      ST_SCHK: begin
        if (crd.mark == MARK_NONE) begin
          state_nxt = ST_IDLE;
        end else begin
          cmem_we    = 1'b1;
          imem_raddr = crd.code[SLOT_W-1:0];
          imem_re    = is_icon && (32'(crd.code) < ICON_SLOTS);
          iok_nxt    = imem_re && ivld_r[imem_raddr];
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          case (seq_r)
            SEQ_CGRAM: ld_byte = CMD_CGRAM | {3'b000, code_r[1:0], 3'b000};
            SEQ_HOME:  ld_byte = CMD_GOTO;
            SEQ_GOTO:  ld_byte = CMD_GOTO | (line_base(y_r) + 8'(x_r));
            SEQ_DATA: begin
              ld_byte = code_r;
              ld_data = 1'b1;
              ld_last = 1'b1;
            end
            default: begin
              ld_byte = (iok_r ? imem_rdata_r[{row_idx, 3'b000} +: 8] : 8'h00) ^ ROW_XOR;
              ld_data = 1'b1;
            end
          endcase
          if (seq_r == SEQ_DATA) state_nxt = ST_IDLE;
        end
      end
      ST_BLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_kind   = 1'b1;
          ld_chg    = bld_chg;
          ld_last   = 1'b1;
          imem_we   = bld_chg;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmem_we) cell_mem[addr_r] <= cmem_wdata;
    if (cmem_re) cmem_rdata_r <= cell_mem[cmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (imem_we) icon_mem[slot_idx] <= imem_wdata;
    if (imem_re) imem_rdata_r <= icon_mem[imem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cvld_r      <= '0;
      ivld_r      <= '0;
      scan_cell_r <= '0;
      scan_x_r    <= '0;
      scan_y_r    <= '0;
      out_vld_r   <= 1'b0;
      iok_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iok_r   <= iok_nxt;
      if (cmem_we) cvld_r[addr_r] <= 1'b1;
      if (imem_we) ivld_r[slot_idx] <= 1'b1;
      if (in_xfer && (in_tuser == ACT_SCAN)) begin
        if (32'(scan_cell_r) == NCELLS - 1) begin
          scan_cell_r <= '0;
          scan_x_r    <= '0;
          scan_y_r    <= '0;
        end else begin
          scan_cell_r <= scan_cell_r + 1'b1;
          if (32'(scan_x_r) == COLS - 1) begin
            scan_x_r <= '0;
            scan_y_r <= scan_y_r + 1'b1;
          end else begin
            scan_x_r <= scan_x_r + 1'b1;
          end
        end
      end
      if (out_load) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fld_r     <= in_f;
      slot_ok_r <= slot_ok;
      addr_r    <= (in_tuser == ACT_SCAN) ? scan_cell_r : wr_addr;
      x_r       <= scan_x_r;
      y_r       <= scan_y_r;
    end
    if (state_r == ST_SCHK) begin
      code_r <= crd.code;
      seq_r  <= is_icon ? SEQ_CGRAM : SEQ_GOTO;
    end else if (out_load) begin
      seq_r <= seq_r + 4'd1;
    end
    if (out_load) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      out_data_r <= ld_data;
      out_chg_r  <= ld_chg;
      out_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b000000, out_chg_r, out_data_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[8:0] == 9'h000))
    else $error("status result not a lone zero-byte transfer");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser |-> out_tdata[8] && !out_tdata[9])
    else $error("scan run does not end on a data byte");

  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == ACT_SCAN) |=>
      (scan_cell_r == ((32'($past(scan_cell_r)) == NCELLS - 1) ? '0
                                                               : $past(scan_cell_r) + 1'b1)))
    else $error("scan position did not advance");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_cell_r) < NCELLS)
    else $error("scan position beyond the grid");
`endif

endmodule

`default_nettype wire
